// ----- design/sign_partitioned_sorter_defines.svh -----
// Assertion macros shared by the sign-partitioned sorter RTL.
`ifndef SIGN_PARTITIONED_SORTER_DEFINES_SVH
`define SIGN_PARTITIONED_SORTER_DEFINES_SVH

// Check a property on every rising edge, suspended while reset is held.
`define SPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define SPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/sps_pkg.sv -----
// Shared types and constants for the sign-partitioned sorter.
`default_nettype none
package sps_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic [DATA_W-1:0] data_t;

  // Sign class remembered for each list position
  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_POS  = 2'd1,
    CLS_NEG  = 2'd2
  } cls_t;

  // Controller state
  typedef enum logic {
    ST_LOAD = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

  // Commands broadcast to every cell of the row
  typedef struct packed {
    logic  ins_neg;    // insert value into the negative chain
    logic  ins_pos;    // insert value into the positive chain
    logic  shift_neg;  // advance negative chain toward cell 0
    logic  shift_pos;  // advance positive chain toward cell 0
    logic  shift_cls;  // advance class chain toward cell 0
    logic  clear;      // drop all chain entries
    data_t value;      // element being inserted
  } cell_ctrl_t;

  // What one cell hands to its neighbors
  typedef struct packed {
    data_t neg;
    data_t pos;
    logic  neg_valid;
    logic  pos_valid;
    logic  neg_move;
    logic  pos_move;
    cls_t  cls;
  } cell_link_t;

endpackage
`default_nettype wire

// ----- design/sps_cell.sv -----
// One cell of the sorter row: a class slot and one entry of each sorted chain.
`default_nettype none
module sps_cell
  import sps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic       cls_we,
  input  cls_t       cls_in,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t self
);

  data_t neg_r, neg_nxt;
  data_t pos_r, pos_nxt;
  logic  neg_valid_r, neg_valid_nxt;
  logic  pos_valid_r, pos_valid_nxt;
  cls_t  cls_r, cls_nxt;
  logic  neg_move;
  logic  pos_move;

  // Entry must step right to make room: ascending negatives, descending positives
  assign neg_move = neg_valid_r && ($signed(neg_r) > $signed(ctrl.value));
  assign pos_move = pos_valid_r && ($signed(pos_r) < $signed(ctrl.value));

  // Negative chain entry
  always_comb begin
    neg_nxt       = neg_r;
    neg_valid_nxt = neg_valid_r;
    if (ctrl.clear) begin
      neg_valid_nxt = 1'b0;
    end else if (ctrl.ins_neg) begin
      neg_valid_nxt = neg_valid_r | left.neg_valid;
      if (left.neg_move) begin
        neg_nxt = left.neg;
      end else if (neg_move || (left.neg_valid && !neg_valid_r)) begin
        neg_nxt = ctrl.value;
      end
    end else if (ctrl.shift_neg) begin
      neg_nxt = right.neg;
    end
  end

  // Positive chain entry
  always_comb begin
    pos_nxt       = pos_r;
    pos_valid_nxt = pos_valid_r;
    if (ctrl.clear) begin
      pos_valid_nxt = 1'b0;
    end else if (ctrl.ins_pos) begin
      pos_valid_nxt = pos_valid_r | left.pos_valid;
      if (left.pos_move) begin
        pos_nxt = left.pos;
      end else if (pos_move || (left.pos_valid && !pos_valid_r)) begin
        pos_nxt = ctrl.value;
      end
    end else if (ctrl.shift_pos) begin
      pos_nxt = right.pos;
    end
  end

  // Class slot: written at its load position, advanced during emission
  always_comb begin
    cls_nxt = cls_r;
    if (cls_we) begin
      cls_nxt = cls_in;
    end else if (ctrl.shift_cls) begin
      cls_nxt = right.cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_valid_r <= 1'b0;
      pos_valid_r <= 1'b0;
    end else begin
      neg_valid_r <= neg_valid_nxt;
      pos_valid_r <= pos_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    pos_r <= pos_nxt;
    cls_r <= cls_nxt;
  end

  assign self.neg       = neg_r;
  assign self.pos       = pos_r;
  assign self.neg_valid = neg_valid_r;
  assign self.pos_valid = pos_valid_r;
  assign self.neg_move  = neg_move;
  assign self.pos_move  = pos_move;
  assign self.cls       = cls_r;

endmodule
`default_nettype wire

// ----- design/sign_partitioned_sorter.sv -----
// Loads at most MAX_ITEMS elements, one per cycle, into a row of insertion cells;
// after the element marked last it emits the rearranged list, one result per cycle
// while out_tready does not stall it; each result is registered in the output register.
// Input is accepted one element per cycle while loading and stalls during emission.
// Reset clears the state, counters, chain occupancy and output valid; data is not cleared.
`default_nettype none
module sign_partitioned_sorter
  import sps_pkg::*;
#(
  parameter int MAX_ITEMS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,   // is_final
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,  // run_end
  output logic        out_tuser   // [0] overflow
);

  `include "sign_partitioned_sorter_defines.svh"

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  state_t         state_r, state_nxt;
  logic [CW-1:0]  load_cnt_r, load_cnt_nxt;
  logic [CW-1:0]  remain_r, remain_nxt;
  logic           dropped_r, dropped_nxt;
  logic           ovf_r, ovf_nxt;
  logic           out_valid_r, out_valid_nxt;
  data_t          out_data_r, out_data_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_ovf_r, out_ovf_nxt;

  logic           load_fire;
  logic           full;
  logic           emit_fire;
  cls_t           in_cls;
  cell_ctrl_t     ctrl;
  cell_link_t     links [MAX_ITEMS];
  cell_link_t     lefts [MAX_ITEMS];
  cell_link_t     rights [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] neg_valid_vec;
  logic [MAX_ITEMS-1:0] pos_valid_vec;

  assign in_tready = (state_r == ST_LOAD);
  assign load_fire = in_tvalid && in_tready;
  assign full      = (load_cnt_r == FULL_CNT);
  assign emit_fire = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  // Classify the incoming element
  always_comb begin
    if (in_tdata == '0) begin
      in_cls = CLS_ZERO;
    end else if (in_tdata[31]) begin
      in_cls = CLS_NEG;
    end else begin
      in_cls = CLS_POS;
    end
  end

  // Broadcast commands to the row
  always_comb begin
    ctrl.value     = in_tdata;
    ctrl.ins_neg   = load_fire && !full && (in_cls == CLS_NEG);
    ctrl.ins_pos   = load_fire && !full && (in_cls == CLS_POS);
    ctrl.shift_cls = emit_fire;
    ctrl.shift_neg = emit_fire && (links[0].cls == CLS_NEG);
    ctrl.shift_pos = emit_fire && (links[0].cls == CLS_POS);
    ctrl.clear     = emit_fire && (remain_r == ONE_CNT);
  end

  // Row of cells, each linked to both neighbors
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    if (i == 0) begin : g_head
      always_comb begin
        lefts[i]           = '0;
        lefts[i].neg_valid = 1'b1;
        lefts[i].pos_valid = 1'b1;
      end
    end else begin : g_body
      assign lefts[i] = links[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      always_comb begin
        rights[i]     = '0;
        rights[i].cls = CLS_ZERO;
      end
    end else begin : g_mid
      assign rights[i] = links[i+1];
    end

    sps_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .cls_we (load_fire && !full && (load_cnt_r == CW'(i))),
      .cls_in (in_cls),
      .left   (lefts[i]),
      .right  (rights[i]),
      .self   (links[i])
    );

    assign neg_valid_vec[i] = links[i].neg_valid;
    assign pos_valid_vec[i] = links[i].pos_valid;
  end

  // Controller: count loads, start and finish emission
  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    remain_nxt   = remain_r;
    dropped_nxt  = dropped_r;
    ovf_nxt      = ovf_r;
    case (state_r)
      ST_LOAD: begin
        if (load_fire) begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            load_cnt_nxt = load_cnt_r + ONE_CNT;
          end
          if (in_tlast) begin
            state_nxt    = ST_EMIT;
            remain_nxt   = full ? FULL_CNT : (load_cnt_r + ONE_CNT);
            ovf_nxt      = dropped_r | full;
            dropped_nxt  = 1'b0;
            load_cnt_nxt = '0;
          end
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          remain_nxt = remain_r - ONE_CNT;
          if (remain_r == ONE_CNT) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Output register: refill from the head cell, hold while stalled
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = (remain_r == ONE_CNT);
      out_ovf_nxt   = ovf_r;
      case (links[0].cls)
        CLS_NEG: out_data_nxt = links[0].neg;
        CLS_POS: out_data_nxt = links[0].pos;
        default: out_data_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      load_cnt_r  <= '0;
      remain_r    <= '0;
      dropped_r   <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      remain_r    <= remain_nxt;
      dropped_r   <= dropped_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  `SPS_ASSERT(a_load_cnt_bound, load_cnt_r <= FULL_CNT, "load count beyond capacity")
  `SPS_ASSERT(a_emit_nonempty, (state_r == ST_EMIT) |-> (remain_r != '0), "emission with nothing left")
  `SPS_ASSERT(a_last_ends_emit, (emit_fire && (remain_r == ONE_CNT)) |=> (state_r == ST_LOAD), "emission did not end after last result")
  `SPS_ASSERT(a_chain_occupancy, (state_r == ST_LOAD) |-> (($countones(neg_valid_vec) + $countones(pos_valid_vec)) <= int'(load_cnt_r)), "chain occupancy exceeds loaded count")

endmodule
`default_nettype wire
